// ----- rtl/core/pht_pkg.sv -----
package pht_pkg;

	localparam int unsigned BUCKETS_DEF    = 64;
	localparam int unsigned WAYS_DEF       = 4;
	localparam int unsigned VALUE_BITS_DEF = 32;

	localparam int unsigned KIND_W   = 2;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned NV_W     = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FOUND_W  = 32;
	localparam int unsigned LIVE_W   = 9;
	localparam int unsigned MASK_W   = 6;

	localparam logic [MASK_W-1:0] MASK_RESET = 6'd63;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_READ,
		S_CMP,
		S_COMMIT
	} state_t;

endpackage

// ----- rtl/core/pht_ram.sv -----
module pht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/process_id_hash_table_top.sv -----
// Channel  Signals                                       Dir  Transfer
// item     item_valid, item_stall, kind, cell_id,        in   valid & !stall
//          job_id, rank_id, new_value
// result   result_valid, result_stall, status,           out  valid & !stall
//          found_value, live_entries
// config   bucket_mask_we, bucket_mask_wdata             in   we
//
// Each item passes a reduce step, repeated while the masked key is at least BUCKETS
// (only possible when BUCKETS < 64), then one RAM read and one compare per way through
// the single read port and way comparator, then a commit step.
// Reset clears valid bits and live count at once; no clearing pass.
// The result register holds one result; the next item is taken while it waits,
// and commit waits only while that result is still stalled.
module process_id_hash_table_top #(
	parameter int unsigned BUCKETS    = pht_pkg::BUCKETS_DEF,
	parameter int unsigned WAYS       = pht_pkg::WAYS_DEF,
	parameter int unsigned VALUE_BITS = pht_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          bucket_mask_we,
	input  logic [pht_pkg::MASK_W-1:0]    bucket_mask_wdata,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [pht_pkg::KIND_W-1:0]    kind,
	input  logic [pht_pkg::KEY_W-1:0]     cell_id,
	input  logic [pht_pkg::KEY_W-1:0]     job_id,
	input  logic [pht_pkg::KEY_W-1:0]     rank_id,
	input  logic [pht_pkg::NV_W-1:0]      new_value,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pht_pkg::STATUS_W-1:0]  status,
	output logic [pht_pkg::FOUND_W-1:0]   found_value,
	output logic [pht_pkg::LIVE_W-1:0]    live_entries
);

	import pht_pkg::*;

	localparam int unsigned ENTRIES = BUCKETS * WAYS;
	localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
	localparam int unsigned WORD_W  = 3 * KEY_W + VALUE_BITS;

	state_t state_q, state_d;

	logic [MASK_W-1:0]     mask_q;
	logic [KIND_W-1:0]     kind_q;
	logic [KEY_W-1:0]      cell_q, job_q, rank_q;
	logic [VALUE_BITS-1:0] nv_q;
	logic [MASK_W-1:0]     red_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [WAY_W-1:0]      way_q;
	logic                  hit_q, free_q;
	logic [ADDR_W-1:0]     hit_addr_q, free_addr_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  res_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [FOUND_W-1:0]    found_q;
	logic [LIVE_W-1:0]     live_q;

	logic [KEY_W-1:0]      folded;
	logic                  accept, commit, red_big, way_last, match;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [WORD_W-1:0]     ram_wdata, ram_rdata;
	logic [KEY_W-1:0]      rd_cell, rd_job, rd_rank;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  is_set, is_remove;
	logic [STATUS_W-1:0]   status_d;
	logic [FOUND_W-1:0]    found_d;
	logic [CNT_W-1:0]      cnt_d;

	assign folded   = (cell_id << 24) + (job_id << 16) + rank_id;
	assign accept   = item_valid && !item_stall;
	assign red_big  = 32'(red_q) >= 32'(BUCKETS);
	assign way_last = way_q == WAY_W'(WAYS - 1);
	assign {rd_cell, rd_job, rd_rank, rd_val} = ram_rdata;
	assign match = valid_q[addr_q] && rd_cell == cell_q && rd_job == job_q
		&& rd_rank == rank_q;
	assign is_set    = kind_q == KIND_SET;
	assign is_remove = kind_q == KIND_REMOVE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		commit     = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = hit_q ? hit_addr_q : free_addr_q;
		ram_wdata  = {cell_q, job_q, rank_q, nv_q};
		status_d   = ST_OK;
		found_d    = '0;
		cnt_d      = cnt_q;
		if (is_set) begin
			if (!hit_q && free_q) begin
				cnt_d = cnt_q + CNT_W'(1);
			end else if (!hit_q) begin
				status_d = ST_FULL;
			end
		end else if (is_remove) begin
			if (hit_q) begin
				cnt_d = cnt_q - CNT_W'(1);
			end else begin
				status_d = ST_MISS;
			end
		end else begin
			if (hit_q) begin
				found_d = FOUND_W'(hit_val_q);
			end else begin
				status_d = ST_MISS;
			end
		end
		unique case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					state_d = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (!red_big) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (way_last) begin
					state_d = S_COMMIT;
				end else begin
					state_d = S_READ;
				end
			end
			S_COMMIT: begin
				if (!(res_valid_q && result_stall)) begin
					commit  = 1'b1;
					ram_we  = is_set && (hit_q || free_q);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= MASK_RESET;
			valid_q     <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (bucket_mask_we) begin
				mask_q <= bucket_mask_wdata;
			end
			if (commit) begin
				res_valid_q <= 1'b1;
				cnt_q       <= cnt_d;
				if (is_set && !hit_q && free_q) begin
					valid_q[free_addr_q] <= 1'b1;
				end else if (is_remove && hit_q) begin
					valid_q[hit_addr_q] <= 1'b0;
				end
			end else if (result_valid && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			cell_q <= cell_id;
			job_q  <= job_id;
			rank_q <= rank_id;
			nv_q   <= VALUE_BITS'(new_value);
			red_q  <= MASK_W'(folded) & mask_q;
		end
		if (state_q == S_REDUCE) begin
			if (red_big) begin
				red_q <= red_q - MASK_W'(BUCKETS);
			end
			addr_q <= ADDR_W'(32'(red_q) * WAYS);
			way_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end
		if (state_q == S_CMP) begin
			if (match && !hit_q) begin
				hit_q      <= 1'b1;
				hit_addr_q <= addr_q;
				hit_val_q  <= rd_val;
			end
			if (!valid_q[addr_q] && !free_q) begin
				free_q      <= 1'b1;
				free_addr_q <= addr_q;
			end
			if (!way_last) begin
				addr_q <= addr_q + ADDR_W'(1);
				way_q  <= way_q + WAY_W'(1);
			end
		end
		if (commit) begin
			status_q <= status_d;
			found_q  <= found_d;
			live_q   <= LIVE_W'(cnt_d);
		end
	end

	pht_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(addr_q),
		.rd_data(ram_rdata)
	);

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign found_value  = found_q;
	assign live_entries = live_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_q)) == 32'(cnt_q))
		else $error("live count differs from valid bits");

	a_bucket_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> 32'(addr_q) < ENTRIES)
		else $error("bucket address beyond table");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		commit && is_set && !hit_q && free_q |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not bump live count");

	a_remove_counts: assert property (@(posedge clk) disable iff (!arst_n)
		commit && is_remove && hit_q |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("remove did not drop live count");

	a_full_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !is_set |=> status_q != ST_FULL)
		else $error("full status on a non-set operation");

endmodule
